[rtl/jsu_pkg.sv]
package jsu_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NO_QUOTE = 3'd1,
    ERR_CTRL     = 3'd2,
    ERR_ESC      = 3'd3,
    ERR_HEX      = 3'd4,
    ERR_SURR     = 3'd5
  } err_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [4:0] SURR_TOP = 5'b11011;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    kind_t           kind;
    err_t            err;
  } grp_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, 4'(c[3:0] + 4'd9)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

[rtl/jsu_decode.sv]
module jsu_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    char_in,
  output jsu_pkg::grp_t grp
);
  import jsu_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hex_count_r, hex_count_nxt;
  logic [15:0] code_accum_r, code_accum_nxt;

  logic [4:0]  hval;
  logic [15:0] acc_new;
  logic        hex_bad, hex_done, surr;
  logic        esc_ok, esc_u;
  logic [7:0]  esc_byte;

  assign hval     = hex_value(char_in);
  assign hex_bad  = hval[4];
  assign acc_new  = {code_accum_r[11:0], hval[3:0]};
  assign hex_done = (hex_count_r == 2'd3);
  assign surr     = (acc_new[15:11] == SURR_TOP);

  always_comb begin
    esc_ok   = 1'b1;
    esc_u    = 1'b0;
    esc_byte = char_in;
    unique case (char_in)
      CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = char_in;
      CH_B: esc_byte = 8'h08;
      CH_F: esc_byte = 8'h0C;
      CH_N: esc_byte = 8'h0A;
      CH_R: esc_byte = 8'h0D;
      CH_T: esc_byte = 8'h09;
      CH_U: esc_u    = 1'b1;
      default: esc_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    hex_count_nxt  = hex_count_r;
    code_accum_nxt = code_accum_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (char_in == CH_QUOTE) begin
          phase_nxt = PH_STR;
        end else begin
          hex_count_nxt  = 2'd0;
          code_accum_nxt = 16'd0;
        end
      end
      PH_STR: begin
        if (char_in == CH_QUOTE || char_in < CTRL_LIMIT) begin
          phase_nxt      = PH_IDLE;
          hex_count_nxt  = 2'd0;
          code_accum_nxt = 16'd0;
        end else if (char_in == CH_BSLASH) begin
          phase_nxt = PH_ESC;
        end
      end
      PH_ESC: begin
        if (!esc_ok) begin
          phase_nxt      = PH_IDLE;
          hex_count_nxt  = 2'd0;
          code_accum_nxt = 16'd0;
        end else if (esc_u) begin
          phase_nxt      = PH_HEX;
          hex_count_nxt  = 2'd0;
          code_accum_nxt = 16'd0;
        end else begin
          phase_nxt = PH_STR;
        end
      end
      PH_HEX: begin
        if (hex_bad || (hex_done && surr)) begin
          phase_nxt      = PH_IDLE;
          hex_count_nxt  = 2'd0;
          code_accum_nxt = 16'd0;
        end else if (!hex_done) begin
          hex_count_nxt  = 2'(hex_count_r + 2'd1);
          code_accum_nxt = acc_new;
        end else begin
          phase_nxt      = PH_STR;
          hex_count_nxt  = 2'd0;
          code_accum_nxt = 16'd0;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    grp = '{cnt: 2'd0, bytes: '0, kind: KIND_BYTE, err: ERR_NONE};
    unique case (phase_r)
      PH_IDLE: begin
        if (char_in != CH_QUOTE) begin
          grp.cnt  = 2'd1;
          grp.kind = KIND_ERR;
          grp.err  = ERR_NO_QUOTE;
        end
      end
      PH_STR: begin
        if (char_in == CH_QUOTE) begin
          grp.cnt  = 2'd1;
          grp.kind = KIND_END;
        end else if (char_in < CTRL_LIMIT) begin
          grp.cnt  = 2'd1;
          grp.kind = KIND_ERR;
          grp.err  = ERR_CTRL;
        end else if (char_in != CH_BSLASH) begin
          grp.cnt      = 2'd1;
          grp.bytes[0] = char_in;
        end
      end
      PH_ESC: begin
        if (!esc_ok) begin
          grp.cnt  = 2'd1;
          grp.kind = KIND_ERR;
          grp.err  = ERR_ESC;
        end else if (!esc_u) begin
          grp.cnt      = 2'd1;
          grp.bytes[0] = esc_byte;
        end
      end
      PH_HEX: begin
        if (hex_bad) begin
          grp.cnt  = 2'd1;
          grp.kind = KIND_ERR;
          grp.err  = ERR_HEX;
        end else if (hex_done) begin
          if (surr) begin
            grp.cnt  = 2'd1;
            grp.kind = KIND_ERR;
            grp.err  = ERR_SURR;
          end else if (acc_new[15:7] == 9'd0) begin
            grp.cnt      = 2'd1;
            grp.bytes[0] = {1'b0, acc_new[6:0]};
          end else if (acc_new[15:11] == 5'd0) begin
            grp.cnt      = 2'd2;
            grp.bytes[0] = {3'b110, acc_new[10:6]};
            grp.bytes[1] = {2'b10, acc_new[5:0]};
          end else begin
            grp.cnt      = 2'd3;
            grp.bytes[0] = {4'b1110, acc_new[15:12]};
            grp.bytes[1] = {2'b10, acc_new[11:6]};
            grp.bytes[2] = {2'b10, acc_new[5:0]};
          end
        end
      end
      default: grp.cnt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      hex_count_r  <= 2'd0;
      code_accum_r <= 16'd0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      hex_count_r  <= hex_count_nxt;
      code_accum_r <= code_accum_nxt;
    end
  end

  a_hex_count_only_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEX) |-> (hex_count_r == 2'd0))
    else $error("hex digit count left over outside a unicode escape");

endmodule

[rtl/jsu_emit.sv]
module jsu_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  jsu_pkg::grp_t grp,
  output logic          free,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic [1:0]    out_kind,
  output logic [2:0]    out_error_code,
  output logic          out_last
);
  import jsu_pkg::*;

  logic [1:0]      rem_r;
  logic [2:0][7:0] bytes_r;
  kind_t           kind_r;
  err_t            err_r;
  logic            pop, load;

  assign out_valid      = (rem_r != 2'd0);
  assign pop            = out_valid && !out_stall;
  assign free           = !out_valid || (pop && rem_r == 2'd1);
  assign load           = accept && (grp.cnt != 2'd0);
  assign out_byte       = bytes_r[0];
  assign out_kind       = kind_r;
  assign out_error_code = err_r;
  assign out_last       = (rem_r == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else if (load) begin
      rem_r <= grp.cnt;
    end else if (pop) begin
      rem_r <= 2'(rem_r - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= grp.bytes;
      kind_r  <= grp.kind;
      err_r   <= grp.err;
    end else if (pop) begin
      bytes_r <= {8'h00, bytes_r[2], bytes_r[1]};
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("word group loaded over a pending group");

  a_marker_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_BYTE) |-> out_last)
    else $error("end or error word not last of its group");

  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !out_last) |=> (out_valid && out_kind == KIND_BYTE))
    else $error("multi-byte group cut short");

endmodule

[rtl/json_string_unescape_core.sv]
// JSON string unescaper: one raw byte of JSON text in, decoded string bytes out.
// Input channel: in_valid / in_stall carry in_char_in, one byte per word.
// Result channel: out_valid / out_stall carry out_byte, out_kind (0 byte,
// 1 string end, 2 error), out_error_code and out_last, which marks the final
// word caused by one input byte. An input byte gives zero to three words.
// A result word is registered and appears in the cycle after its input byte is taken.
// Throughput: one input byte per cycle while out_stall is low and each byte gives
// at most one word; a \uXXXX escape that encodes to two or three UTF-8 bytes
// holds the input while the result register drains them.
// The result register is the only buffer; in_stall rises while it holds
// words that will not all leave in the current cycle, so a stall on the
// result channel reaches the input channel in the same cycle.
// Reset (rst_n low, synchronous) empties the result register and returns the
// decoder to waiting for an opening quote. After a string end or any error
// the decoder again waits for an opening quote.
module json_string_unescape_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic [2:0] out_error_code,
  output logic       out_last
);
  import jsu_pkg::*;

  grp_t grp;
  logic free;
  logic accept;

  assign in_stall = !free;
  assign accept   = in_valid && free;

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .char_in (in_char_in),
    .grp     (grp)
  );

  jsu_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .grp            (grp),
    .free           (free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

endmodule
